// ===== design/rspe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rspe_pkg: shared types and GF(256) helpers for the parity encoder
// Field polynomial 0x11D, primitive element 2, up to MAX_PARITY parity bytes.
// ----------------------------------------------------------------------------
package rspe_pkg;

  localparam int MAX_PARITY = 32;
  localparam int CNT_W      = $clog2(MAX_PARITY + 1);
  localparam int CFG_W      = 6;

  localparam logic [8:0]       GF_POLY  = 9'h11D;
  localparam logic [CNT_W-1:0] EC_RESET = CNT_W'(10);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       parity_last;
  } out_t;

  // Per-cycle commands that the top level broadcasts along the cell row.
  typedef struct packed {
    logic gen_clear;   // drop the generator coefficient to zero
    logic gen_step;    // multiply generator by (x + root)
    logic rem_clear;   // drop the remainder
    logic absorb;      // take one data byte
    logic last;        // the byte taken closes the block
    logic par_load;    // copy the updated remainder into the parity shifter
    logic par_shift;   // advance the parity shifter by one byte
  } cell_ctrl_t;

  // Multiply a by 2 modulo the field polynomial.
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    logic [8:0] t;
    t = {a, 1'b0};
    if (t[8]) begin
      t = t ^ GF_POLY;
    end
    return t[7:0];
  endfunction

  // Shift-and-add multiply over GF(256).
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

  // Saturate the written parity count to 1..MAX_PARITY.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_PARITY) begin
      r = CNT_W'(MAX_PARITY);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/rspe_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rspe_cell: one tap of the parity LFSR
// Holds one remainder byte, one generator coefficient and one parity byte.
// ----------------------------------------------------------------------------
module rspe_cell (
  input  wire logic                  clk,
  input  wire rspe_pkg::cell_ctrl_t  ctrl,
  input  wire logic [7:0]            fb,        // broadcast feedback byte
  input  wire logic [7:0]            root,      // root for the generator build
  input  wire logic [7:0]            rem_in,    // remainder of the next higher cell
  input  wire logic [7:0]            gen_in,    // coefficient of the previous cell
  input  wire logic [7:0]            par_in,    // parity byte of the next higher cell
  output logic      [7:0]            rem,
  output logic      [7:0]            gen,
  output logic      [7:0]            par
);

  logic [7:0] rem_next;

  assign rem_next = rem_in ^ rspe_pkg::gf_mul(gen, fb);

  always_ff @(posedge clk) begin
    if (ctrl.gen_clear) begin
      gen <= 8'h00;
    end else if (ctrl.gen_step) begin
      gen <= gen ^ rspe_pkg::gf_mul(root, gen_in);
    end

    if (ctrl.rem_clear) begin
      rem <= 8'h00;
    end else if (ctrl.absorb) begin
      rem <= ctrl.last ? 8'h00 : rem_next;
    end

    if (ctrl.par_load) begin
      par <= rem_next;
    end else if (ctrl.par_shift) begin
      par <= par_in;
    end
  end

endmodule
`default_nettype wire

// ===== design/reed_solomon_parity_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_core: systematic RS parity encoder, GF(256)
// Data bytes feed a row of LFSR cells; the block's last byte hands the
// remainder to a parity shifter that streams it out highest order first.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                   payload
//  -------  ---------  --------------------------  ----------------------------
//  data     in         data_valid / data_ready     data_byte, block_end
//  parity   out        parity_valid / parity_ready parity_byte, parity_last
//  cfg      in         cfg_we (no wait)            cfg_wdata = ec_count
//
//  One data request is taken per cycle while data_ready is high; every cell
//  updates in parallel. A block yields n parity requests at one per cycle
//  from the shifter while parity_ready is high, so the next block's data
//  streams in while the previous parity drains. A block_end request waits
//  while the shifter still holds more than its last byte, or while that
//  last byte is stalled. Reset and every cfg write rebuild the generator
//  with data_ready low (n is 10 after reset). A stalled parity output holds.
//
module reed_solomon_parity_encoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       data_valid,
  output logic                            data_ready,
  input  wire rspe_pkg::in_t              data,
  output logic                            parity_valid,
  input  wire logic                       parity_ready,
  output rspe_pkg::out_t                  parity,
  input  wire logic                       cfg_we,
  input  wire logic [rspe_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int N = rspe_pkg::MAX_PARITY;
  localparam int W = rspe_pkg::CNT_W;

  // Neighbor links along the row; the ends are tied off.
  logic [7:0] rem_link [N+1];
  logic [7:0] gen_link [N+1];
  logic [7:0] par_link [N+1];

  logic [W-1:0] n_cnt;      // effective parity count
  logic [W-1:0] bld_cnt;    // generator build steps remaining
  logic [W-1:0] out_cnt;    // parity bytes left to send
  logic [7:0]   root;       // current root a^i during the build

  logic       building;
  logic       out_free;
  logic       take;
  logic       send;
  logic [7:0] fb;

  rspe_pkg::cell_ctrl_t ctrl;

  assign building     = (bld_cnt != '0);
  assign parity_valid = (out_cnt != '0);
  assign send         = parity_valid && parity_ready;
  // Shifter can take a new block once it is empty or sending its last byte.
  assign out_free     = (out_cnt == '0) || ((out_cnt == W'(1)) && parity_ready);
  assign data_ready   = !building && (!data.block_end || out_free);
  assign take         = data_valid && data_ready;

  assign fb = data.data_byte ^ rem_link[0];

  always_comb begin
    ctrl.gen_clear = rst || cfg_we;
    ctrl.gen_step  = building;
    ctrl.rem_clear = rst || cfg_we;
    ctrl.absorb    = take;
    ctrl.last      = data.block_end;
    ctrl.par_load  = take && data.block_end;
    ctrl.par_shift = send;
  end

  assign rem_link[N] = 8'h00;
  assign par_link[N] = 8'h00;
  assign gen_link[0] = 8'h01;   // leading generator coefficient is always 1

  for (genvar k = 0; k < N; k++) begin : g_cell
    rspe_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .fb     (fb),
      .root   (root),
      .rem_in (rem_link[k+1]),
      .gen_in (gen_link[k]),
      .par_in (par_link[k+1]),
      .rem    (rem_link[k]),
      .gen    (gen_link[k+1]),
      .par    (par_link[k])
    );
  end

  assign parity.parity_byte = par_link[0];
  assign parity.parity_last = (out_cnt == W'(1));

  // Sequencer: start a generator build on reset or a count write, then
  // advance the root by a each step; track the parity shifter fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_cnt   <= rspe_pkg::EC_RESET;
      bld_cnt <= rspe_pkg::EC_RESET;
      root    <= 8'h01;
      out_cnt <= '0;
    end else begin
      if (cfg_we) begin
        n_cnt   <= rspe_pkg::clamp_count(cfg_wdata);
        bld_cnt <= rspe_pkg::clamp_count(cfg_wdata);
        root    <= 8'h01;
      end else if (building) begin
        bld_cnt <= bld_cnt - W'(1);
        root    <= rspe_pkg::gf_xtime(root);
      end

      if (take && data.block_end) begin
        out_cnt <= n_cnt;
      end else if (send) begin
        out_cnt <= out_cnt - W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rspe_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rspe_checker: port-level checks for the parity encoder
// Watches the handshakes and the rebuild window after reset or cfg writes.
// ----------------------------------------------------------------------------
module rspe_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       data_valid,
  input  wire logic                       data_ready,
  input  wire rspe_pkg::in_t              data,
  input  wire logic                       parity_valid,
  input  wire logic                       parity_ready,
  input  wire rspe_pkg::out_t             parity,
  input  wire logic                       cfg_we
);

  // Stalled parity request holds.
  a_parity_hold: assert property (@(posedge clk) disable iff (rst)
    parity_valid && !parity_ready |=> parity_valid && $stable(parity))
    else $error("parity request changed while stalled");

  // Reset leaves nothing to send and a generator build in progress.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !parity_valid && !data_ready)
    else $error("encoder not idle after reset");

  // A count write starts a rebuild, so data is held off next cycle.
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !data_ready)
    else $error("data taken during generator rebuild");

  // Closing a block always produces parity next cycle.
  a_block_parity: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_ready && data.block_end |=> parity_valid)
    else $error("block end without parity output");

endmodule

bind reed_solomon_parity_encoder_core rspe_checker u_rspe_checker (
  .clk          (clk),
  .rst          (rst),
  .data_valid   (data_valid),
  .data_ready   (data_ready),
  .data         (data),
  .parity_valid (parity_valid),
  .parity_ready (parity_ready),
  .parity       (parity),
  .cfg_we       (cfg_we)
);
`default_nettype wire
